/* hw/rtl/ultrasonic_range_averager_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic range averager
// Shorthand for the concurrent checks used at the end of the core and ring modules.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_AVERAGER_CORE_MACROS_SVH
`define ULTRASONIC_RANGE_AVERAGER_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define URAV_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define URAV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define URAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/urav_pkg.sv */
// ----------------------------------------------------------------------------
// Ultrasonic range averager package
// Shared types, register indexes and ranging constants.
// ----------------------------------------------------------------------------
`default_nettype none

package urav_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DIST_W      = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_LOW_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_LOW_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ECHO_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP_VALUE   = 3'd4;

   // Distance in 1/16 cm is ticks * 17827 / 65536, about 16 / 58.82.
   localparam int                DIST_MUL_W = 15;
   localparam logic [14:0]       DIST_MUL   = 15'd17827;
   localparam int                DIST_SHIFT = 16;
   localparam logic [DIST_W-1:0] DIST_MAX   = 13'd6399;

   typedef struct packed {
      logic [7:0]        pre_low_ticks;
      logic [7:0]        high_ticks;
      logic [7:0]        post_low_ticks;
      logic [15:0]       max_echo_ticks;
      logic [DIST_W-1:0] warmup_value;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pre_low_ticks:  8'd20,
      high_ticks:     8'd10,
      post_low_ticks: 8'd20,
      max_echo_ticks: 16'd23528,
      warmup_value:   13'd1600
   };

   typedef struct packed {
      logic trig;
      logic busy;
   } seq_status_type;

   typedef struct packed {
      logic              done;
      logic              in_range;
      logic [DIST_W-1:0] distance;
   } meas_type;

endpackage

`default_nettype wire

/* hw/rtl/ultrasonic_range_averager_core.sv */
// A result beat is registered and appears on rsp in the cycle after its request beat is accepted.
// One beat per cycle while rsp is not stalled; each tick passes the sequencer and ring update once.
// A stalled result is held in the output register while the next beat waits upstream.
// Reset (synchronous) idles the sequencer, clears the ring at once through per-entry
// valid bits and loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
// Ultrasonic range averager core
// Trigger generation, echo timing and a moving average of the measured distance,
// one request beat per microsecond tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ultrasonic_range_averager_core_macros.svh"

module ultrasonic_range_averager_core #(
   parameter int RING_DEPTH = 10,
   parameter int TICK_BITS  = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             csr_wr_en,
   input  wire logic [urav_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [urav_pkg::CSR_DATA_W-1:0]  csr_wdata,

   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_start_req,
   input  wire logic                             req_echo,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_trig,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic                                  rsp_in_range,
   output logic [urav_pkg::DIST_W-1:0]           rsp_distance_q4,
   output logic [urav_pkg::DIST_W-1:0]           rsp_average_q4
);
   import urav_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   seq_status_type status;
   meas_type       meas;
   logic           req_accept;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_trig_ff, rsp_busy_ff, rsp_done_ff, rsp_in_range_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRE_LOW_TICKS:  cfg_in.pre_low_ticks  = csr_wdata[7:0];
            CSR_HIGH_TICKS:     cfg_in.high_ticks     = csr_wdata[7:0];
            CSR_POST_LOW_TICKS: cfg_in.post_low_ticks = csr_wdata[7:0];
            CSR_MAX_ECHO_TICKS: cfg_in.max_echo_ticks = csr_wdata[15:0];
            CSR_WARMUP_VALUE:   cfg_in.warmup_value   = csr_wdata[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   urav_seq #(
      .TICK_BITS (TICK_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .advance       (req_accept),
      .start_req     (req_start_req),
      .echo          (req_echo),
      .cfg           (cfg_ff),
      .status        (status),
      .meas          (meas),
      .last_distance (rsp_distance_q4)
   );

   urav_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock        (clock),
      .reset        (reset),
      .meas         (meas),
      .warmup_value (cfg_ff.warmup_value),
      .average      (rsp_average_q4)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_trig_ff     <= status.trig;
         rsp_busy_ff     <= status.busy;
         rsp_done_ff     <= meas.done;
         rsp_in_range_ff <= meas.done && meas.in_range;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_trig     = rsp_trig_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_in_range = rsp_in_range_ff;

   `URAV_ASSERT_IMPLY(a_done_busy, clock, reset, rsp_valid_ff && rsp_done_ff, rsp_busy_ff, "Measurement completed outside a busy tick.")
   `URAV_ASSERT_IMPLY(a_range_done, clock, reset, rsp_valid_ff && rsp_in_range_ff, rsp_done_ff, "Range flag raised without a completed measurement.")
   `URAV_ASSERT_IMPLY(a_trig_busy, clock, reset, rsp_valid_ff && rsp_trig_ff, rsp_busy_ff && !rsp_done_ff, "Trigger driven outside the pulse phase.")

endmodule

`default_nettype wire

/* hw/rtl/urav_dist.sv */
// ----------------------------------------------------------------------------
// Echo length to distance converter
// Scales an echo tick count to 1/16 cm and saturates at the range limit.
// ----------------------------------------------------------------------------
`default_nettype none

module urav_dist #(
   parameter int TICK_BITS = 16
) (
   input  wire logic [TICK_BITS-1:0]      ticks,
   output logic [urav_pkg::DIST_W-1:0]    distance
);
   import urav_pkg::*;

   localparam int PROD_W = TICK_BITS + DIST_MUL_W;
   localparam int QUOT_W = PROD_W - DIST_SHIFT;
   localparam int CMP_W  = (QUOT_W > DIST_W) ? QUOT_W : DIST_W;

   logic [PROD_W-1:0] product;
   logic [QUOT_W-1:0] quotient;

   always_comb begin
      product  = PROD_W'(ticks) * PROD_W'(DIST_MUL);
      quotient = product[PROD_W-1:DIST_SHIFT];
      if (CMP_W'(quotient) > CMP_W'(DIST_MAX)) begin
         distance = DIST_MAX;
      end else begin
         distance = DIST_W'(quotient);
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/urav_seq.sv */
// ----------------------------------------------------------------------------
// Trigger and echo sequencer
// Steps through the trigger phases, times the echo and reports each completed
// measurement with its distance and range check.
// ----------------------------------------------------------------------------
`default_nettype none

module urav_seq #(
   parameter int TICK_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        start_req,
   input  wire logic                        echo,
   input  wire urav_pkg::cfg_type           cfg,
   output urav_pkg::seq_status_type         status,
   output urav_pkg::meas_type               meas,
   output logic [urav_pkg::DIST_W-1:0]      last_distance
);
   import urav_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_PRE  = 3'd1;
   localparam logic [2:0] PH_HIGH = 3'd2;
   localparam logic [2:0] PH_POST = 3'd3;
   localparam logic [2:0] PH_WAIT = 3'd4;
   localparam logic [2:0] PH_MEAS = 3'd5;

   localparam int                   CMP_W    = (TICK_BITS > 16) ? TICK_BITS : 16;
   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   logic [2:0]           phase_ff, phase_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [DIST_W-1:0]    last_dist_ff, last_dist_in;
   logic [TICK_BITS:0]   tick_inc;
   logic [7:0]           phase_len;
   logic [2:0]           phase_succ;
   logic [DIST_W-1:0]    distance;
   logic                 done;

   function automatic logic [2:0] skip_empty(input logic [2:0] p, input cfg_type c);
      logic [2:0] r;
      r = p;
      if (r == PH_PRE && c.pre_low_ticks == 8'd0) begin
         r = PH_HIGH;
      end
      if (r == PH_HIGH && c.high_ticks == 8'd0) begin
         r = PH_POST;
      end
      if (r == PH_POST && c.post_low_ticks == 8'd0) begin
         r = PH_WAIT;
      end
      return r;
   endfunction

   urav_dist #(
      .TICK_BITS (TICK_BITS)
   ) u_dist (
      .ticks    (tick_ff),
      .distance (distance)
   );

   always_comb begin
      tick_inc   = {1'b0, tick_ff} + 1'b1;
      phase_succ = phase_ff + 3'd1;
      unique case (phase_ff)
         PH_PRE:  phase_len = cfg.pre_low_ticks;
         PH_HIGH: phase_len = cfg.high_ticks;
         default: phase_len = cfg.post_low_ticks;
      endcase

      phase_in     = phase_ff;
      tick_in      = tick_ff;
      last_dist_in = last_dist_ff;
      done         = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               phase_in = skip_empty(PH_PRE, cfg);
               tick_in  = '0;
            end
         end
         PH_PRE, PH_HIGH, PH_POST: begin
            tick_in = tick_inc[TICK_BITS-1:0];
            if (tick_inc >= (TICK_BITS+1)'(phase_len)) begin
               phase_in = skip_empty(phase_succ, cfg);
               tick_in  = '0;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               phase_in = PH_MEAS;
               tick_in  = TICK_BITS'(1);
            end
         end
         PH_MEAS: begin
            if (echo) begin
               if (tick_ff != TICK_MAX) begin
                  tick_in = tick_inc[TICK_BITS-1:0];
               end
            end else begin
               done         = 1'b1;
               last_dist_in = distance;
               phase_in     = PH_IDLE;
               tick_in      = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase

      status.trig   = (phase_ff == PH_HIGH);
      status.busy   = (phase_ff != PH_IDLE);
      meas.done     = advance && done;
      meas.in_range = CMP_W'(tick_ff) < CMP_W'(cfg.max_echo_ticks);
      meas.distance = distance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         last_dist_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         last_dist_ff <= last_dist_in;
      end
   end

   assign last_distance = last_dist_ff;

endmodule

`default_nettype wire

/* hw/rtl/urav_ring.sv */
// ----------------------------------------------------------------------------
// Distance ring and running average
// Keeps the last in-range distances, their running sum and the attempt count;
// gives warmup_value until depth attempts, then the sum divided by the depth.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ultrasonic_range_averager_core_macros.svh"

module urav_ring #(
   parameter int RING_DEPTH = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire urav_pkg::meas_type          meas,
   input  wire logic [urav_pkg::DIST_W-1:0] warmup_value,
   output logic [urav_pkg::DIST_W-1:0]      average
);
   import urav_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int ATT_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = DIST_W + $clog2(RING_DEPTH);

   // Reciprocal of the depth, exact for every sum below 2**SUM_W.
   localparam int              RECIP_SHIFT = SUM_W + $clog2(RING_DEPTH);
   localparam int              RECIP_W     = SUM_W + 2;
   localparam longint unsigned RECIP_L     =
      ((64'd1 << RECIP_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
   localparam int              PROD_W      = SUM_W + RECIP_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
   localparam logic [ATT_W-1:0]  ATT_FULL  = ATT_W'(RING_DEPTH);
   localparam logic [SUM_W-1:0]  SUM_MAX   = SUM_W'(RING_DEPTH * 6399);

   logic [DIST_W-1:0]     ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] valid_ff;
   logic [DIST_W-1:0]     rd_data_ff;
   logic                  rd_valid_ff;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [ATT_W-1:0]      attempts_ff, attempts_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [DIST_W-1:0]     old_entry;
   logic                  store;
   logic [PROD_W-1:0]     product;
   logic [DIST_W-1:0]     warmup_sat;

   always_comb begin
      store       = meas.done && meas.in_range;
      old_entry   = rd_valid_ff ? rd_data_ff : '0;
      sum_in      = sum_ff - SUM_W'(old_entry) + SUM_W'(meas.distance);
      slot_in     = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      attempts_in = (attempts_ff == ATT_FULL) ? attempts_ff : attempts_ff + 1'b1;

      warmup_sat = (warmup_value > DIST_MAX) ? DIST_MAX : warmup_value;
      product    = PROD_W'(sum_ff) * PROD_W'(RECIP);
      if (attempts_ff != ATT_FULL) begin
         average = warmup_sat;
      end else begin
         average = product[RECIP_SHIFT +: DIST_W];
      end
   end

   // The slot read is prefetched; a new slot settles well before the next
   // measurement can complete.
   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[slot_ff];
      if (store) begin
         ring_mem[slot_ff] <= meas.distance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         slot_ff     <= '0;
         attempts_ff <= '0;
         sum_ff      <= '0;
      end else begin
         rd_valid_ff <= valid_ff[slot_ff];
         if (store) begin
            valid_ff[slot_ff] <= 1'b1;
            sum_ff            <= sum_in;
         end
         if (meas.done) begin
            slot_ff     <= slot_in;
            attempts_ff <= attempts_in;
         end
      end
   end

   `URAV_ASSERT_NEXT(a_done_spaced, clock, reset, meas.done, !meas.done, "Measurements completed in consecutive cycles.")
   `URAV_ASSERT_ALWAYS(a_sum_bound, clock, reset, sum_ff <= SUM_MAX, "Ring sum exceeds the largest possible total.")
   `URAV_ASSERT_ALWAYS(a_slot_bound, clock, reset, slot_ff <= SLOT_LAST, "Write slot is outside the ring.")
   `URAV_ASSERT_ALWAYS(a_attempts_bound, clock, reset, attempts_ff <= ATT_FULL, "Attempt count passed the ring depth.")

endmodule

`default_nettype wire
